// ===== hdl/p2p_pkg.sv =====
package p2p_pkg;

    // digit width of the partial-product multipliers
    localparam int MUL_DIGIT = 32;

    // default coordinate width, signed Q16.16
    localparam int COORD_WIDTH_DEF = 32;

endpackage

// ===== hdl/point_to_plane_projection_core.sv =====
// Projects a query point P onto the plane through vertices A, B, C:
// P - N*(N.(P-A))/|N|^2 with N = (A-C)x(B-C), rounded once, then saturated.
//
// Input channel: in_valid / in_stall with the twelve coordinate ports.
// Output channel: out_valid / out_stall with proj_x/y/z, degenerate and
// saturated. A beat moves when valid is high and stall is low.
//
// Throughput is one beat per cycle while a held output beat does not
// stall the pipeline. The stages are, in order: input difference stage,
// cross product multipliers, normal stage, dot and norm multipliers,
// sum stage, scale multipliers, rounding divider and the clamp/output
// stage. Multipliers take one 32x32 digit product per stage, the divider
// one quotient bit per stage.
//
// The whole pipeline advances together; when the receiver stalls a valid
// output, every stage holds and in_stall rises in the same cycle. Bubbles
// are kept in place. Reset clears all valid bits; nothing else needs it.
// A zero |N|^2 passes P through with degenerate set.
module point_to_plane_projection_core
    import p2p_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] vertex_a_x,
    input  logic signed [COORD_WIDTH-1:0] vertex_a_y,
    input  logic signed [COORD_WIDTH-1:0] vertex_a_z,
    input  logic signed [COORD_WIDTH-1:0] vertex_b_x,
    input  logic signed [COORD_WIDTH-1:0] vertex_b_y,
    input  logic signed [COORD_WIDTH-1:0] vertex_b_z,
    input  logic signed [COORD_WIDTH-1:0] vertex_c_x,
    input  logic signed [COORD_WIDTH-1:0] vertex_c_y,
    input  logic signed [COORD_WIDTH-1:0] vertex_c_z,
    input  logic signed [COORD_WIDTH-1:0] query_x,
    input  logic signed [COORD_WIDTH-1:0] query_y,
    input  logic signed [COORD_WIDTH-1:0] query_z,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [COORD_WIDTH-1:0] proj_x,
    output logic signed [COORD_WIDTH-1:0] proj_y,
    output logic signed [COORD_WIDTH-1:0] proj_z,
    output logic                          degenerate,
    output logic                          saturated
);

    localparam int DW  = COORD_WIDTH + 1;
    localparam int NW  = 2 * DW + 1;
    localparam int DPW = NW + DW + 2;
    localparam int SW  = 2 * NW + 2;
    localparam int NDW = NW + DPW;
    localparam int QB  = COORD_WIDTH + 3;
    localparam int QW  = QB + 1;
    localparam int RW  = COORD_WIDTH + 5;

    localparam int NGD = (DW + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int NGN = (NW + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int NGP = (DPW + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int L1  = NGD * NGD + 2;
    localparam int LND = NGN * NGD + 2;
    localparam int L2  = NGN * NGN + 2;
    localparam int L3  = NGN * NGP + 2;
    localparam int LD  = QB + 2;
    localparam int PL  = 1 + L1 + 1 + L2 + 1 + L3 + LD;
    localparam int T   = PL + 1;

    localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic en;
    logic [T-1:0] vld_reg;

    logic signed [COORD_WIDTH-1:0] va [3];
    logic signed [COORD_WIDTH-1:0] vb [3];
    logic signed [COORD_WIDTH-1:0] vc [3];
    logic signed [COORD_WIDTH-1:0] vq [3];

    logic signed [DW-1:0]       x_reg  [3];
    logic signed [DW-1:0]       y_reg  [3];
    logic signed [DW-1:0]       pa_reg [3];
    logic signed [DW-1:0]       pa_d   [3];
    logic signed [2*DW-1:0]     t1     [3];
    logic signed [2*DW-1:0]     t2     [3];
    logic signed [NW-1:0]       n_reg  [3];
    logic signed [NW-1:0]       n_d    [3];
    logic signed [NW+DW-1:0]    nd     [3];
    logic signed [NW+DW-1:0]    nd_d   [3];
    logic signed [2*NW-1:0]     nn     [3];
    logic signed [DPW-1:0]      d_reg;
    logic signed [SW-1:0]       s_reg;
    logic signed [SW-1:0]       s_d;
    logic                       deg_d;
    logic signed [NDW-1:0]      num    [3];
    logic signed [QW-1:0]       qv     [3];
    logic signed [COORD_WIDTH-1:0] p_d [3];
    logic signed [RW-1:0]       r      [3];
    logic [2:0]                 ovf;
    logic signed [COORD_WIDTH-1:0] cl  [3];

    logic signed [COORD_WIDTH-1:0] proj_reg [3];
    logic                          deg_reg;
    logic                          sat_reg;

    // whole pipeline moves unless a finished beat is held at the output
    assign en       = !vld_reg[T-1] || !out_stall;
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[T-2:0], in_valid};
        end
    end

    assign va[0] = vertex_a_x;
    assign va[1] = vertex_a_y;
    assign va[2] = vertex_a_z;
    assign vb[0] = vertex_b_x;
    assign vb[1] = vertex_b_y;
    assign vb[2] = vertex_b_z;
    assign vc[0] = vertex_c_x;
    assign vc[1] = vertex_c_y;
    assign vc[2] = vertex_c_z;
    assign vq[0] = query_x;
    assign vq[1] = query_y;
    assign vq[2] = query_z;

    generate
        for (genvar i = 0; i < 3; i++)
        begin : g_axis
            localparam int J = (i + 1) % 3;
            localparam int K = (i + 2) % 3;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[i]  <= DW'(va[i]) - DW'(vc[i]);
                    y_reg[i]  <= DW'(vb[i]) - DW'(vc[i]);
                    pa_reg[i] <= DW'(vq[i]) - DW'(va[i]);
                end
            end

            p2p_mul #(.AW(DW), .BW(DW)) u_t1
            (
                .clk (clk),
                .en  (en),
                .a   (x_reg[J]),
                .b   (y_reg[K]),
                .p   (t1[i])
            );

            p2p_mul #(.AW(DW), .BW(DW)) u_t2
            (
                .clk (clk),
                .en  (en),
                .a   (x_reg[K]),
                .b   (y_reg[J]),
                .p   (t2[i])
            );

            p2p_dly #(.W(DW), .L(L1 + 1)) u_pa_dly
            (
                .clk (clk),
                .en  (en),
                .d   (pa_reg[i]),
                .q   (pa_d[i])
            );

            // normal component
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    n_reg[i] <= NW'(t1[i]) - NW'(t2[i]);
                end
            end

            p2p_mul #(.AW(NW), .BW(DW)) u_nd
            (
                .clk (clk),
                .en  (en),
                .a   (n_reg[i]),
                .b   (pa_d[i]),
                .p   (nd[i])
            );

            p2p_dly #(.W(NW + DW), .L(L2 - LND)) u_nd_dly
            (
                .clk (clk),
                .en  (en),
                .d   (nd[i]),
                .q   (nd_d[i])
            );

            p2p_mul #(.AW(NW), .BW(NW)) u_nn
            (
                .clk (clk),
                .en  (en),
                .a   (n_reg[i]),
                .b   (n_reg[i]),
                .p   (nn[i])
            );

            p2p_dly #(.W(NW), .L(L2 + 1)) u_n_dly
            (
                .clk (clk),
                .en  (en),
                .d   (n_reg[i]),
                .q   (n_d[i])
            );

            p2p_mul #(.AW(NW), .BW(DPW)) u_scale
            (
                .clk (clk),
                .en  (en),
                .a   (n_d[i]),
                .b   (d_reg),
                .p   (num[i])
            );

            p2p_div #(.NUMW(NDW), .DENW(SW), .QB(QB)) u_div
            (
                .clk (clk),
                .en  (en),
                .num (num[i]),
                .den (s_d),
                .q   (qv[i])
            );

            p2p_dly #(.W(COORD_WIDTH), .L(PL)) u_p_dly
            (
                .clk (clk),
                .en  (en),
                .d   (vq[i]),
                .q   (p_d[i])
            );

            // clamp when the bits above the sign bit disagree
            assign r[i]   = RW'(p_d[i]) - RW'(qv[i]);
            assign ovf[i] = !((&r[i][RW-1:COORD_WIDTH-1]) || !(|r[i][RW-1:COORD_WIDTH-1]));
            assign cl[i]  = ovf[i] ? (r[i][RW-1] ? CMIN : CMAX)
                                   : r[i][COORD_WIDTH-1:0];

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    proj_reg[i] <= deg_d ? p_d[i] : cl[i];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= DPW'(nd_d[0]) + DPW'(nd_d[1]) + DPW'(nd_d[2]);
            s_reg <= SW'(nn[0]) + SW'(nn[1]) + SW'(nn[2]);
        end
    end

    p2p_dly #(.W(SW), .L(L3)) u_s_dly
    (
        .clk (clk),
        .en  (en),
        .d   (s_reg),
        .q   (s_d)
    );

    p2p_dly #(.W(1), .L(L3 + LD)) u_deg_dly
    (
        .clk (clk),
        .en  (en),
        .d   (s_reg == '0),
        .q   (deg_d)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            deg_reg <= deg_d;
            sat_reg <= !deg_d && (|ovf);
        end
    end

    assign out_valid  = vld_reg[T-1];
    assign proj_x     = proj_reg[0];
    assign proj_y     = proj_reg[1];
    assign proj_z     = proj_reg[2];
    assign degenerate = deg_reg;
    assign saturated  = sat_reg;

    a_deg_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> !saturated)
        else $error("degenerate beat flagged as saturated");

    a_sat_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            (proj_x == CMAX || proj_x == CMIN || proj_y == CMAX ||
             proj_y == CMIN || proj_z == CMAX || proj_z == CMIN))
        else $error("saturated beat has no clamped coordinate");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a held output beat");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

endmodule

// ===== hdl/p2p_dly.sv =====
module p2p_dly
    import p2p_pkg::*;
#(
    parameter int W = 1,
    parameter int L = 1
)
(
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    generate
        if (L == 0)
        begin : g_none
            assign q = d;
        end
        else
        begin : g_line
            logic [W-1:0] sh_reg [L];

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sh_reg[0] <= d;
                    for (int k = 1; k < L; k++)
                    begin
                        sh_reg[k] <= sh_reg[k-1];
                    end
                end
            end

            assign q = sh_reg[L-1];
        end
    endgenerate

endmodule

// ===== hdl/p2p_mul.sv =====
module p2p_mul
    import p2p_pkg::*;
#(
    parameter int AW = 33,
    parameter int BW = 33
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [AW-1:0] a,
    input  logic signed [BW-1:0] b,
    output logic signed [AW+BW-1:0] p
);

    localparam int NA   = (AW + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int NB   = (BW + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int NS   = NA * NB;
    localparam int ACCW = (NA + NB) * MUL_DIGIT;
    localparam int PW   = AW + BW;

    logic [AW-1:0] a_mag;
    logic [BW-1:0] b_mag;

    logic [NA*MUL_DIGIT-1:0] ma_reg  [NS+1];
    logic [NB*MUL_DIGIT-1:0] mb_reg  [NS+1];
    logic                    neg_reg [NS+1];
    logic [ACCW-1:0]         acc_reg [NS+1];
    logic [PW-1:0]           p_reg;

    assign a_mag = a[AW-1] ? AW'(-a) : AW'(a);
    assign b_mag = b[BW-1] ? BW'(-b) : BW'(b);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma_reg[0]  <= (NA*MUL_DIGIT)'(a_mag);
            mb_reg[0]  <= (NB*MUL_DIGIT)'(b_mag);
            neg_reg[0] <= a[AW-1] ^ b[BW-1];
            acc_reg[0] <= '0;
        end
    end

    // one digit product per stage, accumulated at its weight
    generate
        for (genvar s = 0; s < NS; s++)
        begin : g_stage
            localparam int IX = s / NB;
            localparam int JX = s % NB;
            logic [2*MUL_DIGIT-1:0] pp;

            assign pp = ma_reg[s][IX*MUL_DIGIT +: MUL_DIGIT]
                      * mb_reg[s][JX*MUL_DIGIT +: MUL_DIGIT];

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    acc_reg[s+1] <= acc_reg[s] + (ACCW'(pp) << (MUL_DIGIT * (IX + JX)));
                    ma_reg[s+1]  <= ma_reg[s];
                    mb_reg[s+1]  <= mb_reg[s];
                    neg_reg[s+1] <= neg_reg[s];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= neg_reg[NS] ? PW'(-acc_reg[NS]) : PW'(acc_reg[NS]);
        end
    end

    assign p = p_reg;

endmodule

// ===== hdl/p2p_div.sv =====
module p2p_div
    import p2p_pkg::*;
#(
    parameter int NUMW = 169,
    parameter int DENW = 136,
    parameter int QB   = 35
)
(
    input  logic                   clk,
    input  logic                   en,
    input  logic signed [NUMW-1:0] num,
    input  logic [DENW-1:0]        den,
    output logic signed [QB:0]     q
);

    localparam int RW = DENW + 1;
    localparam int QW = QB + 1;

    logic [NUMW-1:0] nmag;

    logic [RW-1:0]   rem_reg [QB+1];
    logic [QB-1:0]   low_reg [QB+1];
    logic [QB-1:0]   quo_reg [QB+1];
    logic [DENW-1:0] d_reg   [QB+1];
    logic            neg_reg [QB+1];
    logic [QW-1:0]   q_reg;

    logic          rnd;
    logic [QW-1:0] qm;

    assign nmag = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);

    // quotient magnitude is known to fit in QB bits
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= RW'(nmag >> QB);
            low_reg[0] <= nmag[QB-1:0];
            quo_reg[0] <= '0;
            d_reg[0]   <= den;
            neg_reg[0] <= num[NUMW-1];
        end
    end

    generate
        for (genvar k = 0; k < QB; k++)
        begin : g_bit
            logic [RW-1:0] trial;
            logic          ge;

            assign trial = {rem_reg[k][RW-2:0], low_reg[k][QB-1-k]};
            assign ge    = trial >= {1'b0, d_reg[k]};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1] <= ge ? (trial - {1'b0, d_reg[k]}) : trial;
                    quo_reg[k+1] <= {quo_reg[k][QB-2:0], ge};
                    low_reg[k+1] <= low_reg[k];
                    d_reg[k+1]   <= d_reg[k];
                    neg_reg[k+1] <= neg_reg[k];
                end
            end
        end
    endgenerate

    // round half away from zero on the magnitude
    assign rnd = {rem_reg[QB], 1'b0} >= {2'b00, d_reg[QB]};
    assign qm  = {1'b0, quo_reg[QB]} + QW'(rnd);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= neg_reg[QB] ? QW'(-qm) : qm;
        end
    end

    assign q = q_reg;

endmodule
